### rtl/tdcsu_pkg.sv
// shared types and constants of the tdc subevent unpacker
package tdcsu_pkg;

  localparam int unsigned EPOCH_ENTRIES_DEF = 16;

  localparam logic [15:0] ID_END       = 16'h5555;
  localparam logic [15:0] ID_SKIP_LO   = 16'h7000;
  localparam logic [15:0] ID_SKIP_HI   = 16'h7003;
  localparam logic [15:0] ID_IGNORE_A  = 16'h7005;
  localparam logic [15:0] ID_IGNORE_B  = 16'h0112;
  localparam logic [2:0]  KIND_EPOCH   = 3'd3;

  localparam int unsigned EPOCH_W  = 28;
  localparam int unsigned COARSE_W = 11;
  localparam int unsigned FULL_W   = EPOCH_W + COARSE_W;

  typedef enum logic [2:0] {
    MODE_HEADER = 3'b001,
    MODE_BLOCK  = 3'b010,
    MODE_DONE   = 3'b100
  } mode_t;

endpackage

### rtl/tdcsu_if.sv
// request channel interfaces: subevent words in, decoded hits out
interface tdcsu_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] data_word;
  logic        sub_start;
  logic [15:0] link_id;

  modport source (output valid, data_word, sub_start, link_id, input ready);
  modport sink (input valid, data_word, sub_start, link_id, output ready);
endinterface

interface tdcsu_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] link_number;
  logic [15:0] tdc_number;
  logic [6:0]  channel;
  logic [27:0] epoch_value;
  logic [10:0] coarse_time;
  logic [9:0]  fine_time;
  logic        edge_bit;
  logic [38:0] full_coarse;
  logic        table_overflow;

  modport source (output valid, link_number, tdc_number, channel, epoch_value, coarse_time,
                  fine_time, edge_bit, full_coarse, table_overflow, input ready);
  modport sink (input valid, link_number, tdc_number, channel, epoch_value, coarse_time,
                fine_time, edge_bit, full_coarse, table_overflow, output ready);
endinterface

### rtl/tdc_subevent_unpacker.sv
// top level: streaming tdc subevent parser with an associative epoch table
// a time word's hit appears on the output in the cycle after its request is accepted
// throughput: one word per cycle; the epoch value memory is read at acceptance and its
//   registered read port is the output register, so a stalled hit holds the input
// reset: synchronous, active low; parser to expect header, epoch table valid bits and
//   overflow flag cleared at once, no clearing pass
module tdc_subevent_unpacker #(
  parameter int unsigned EPOCH_ENTRIES = tdcsu_pkg::EPOCH_ENTRIES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  tdcsu_in_if.sink    in_if,
  tdcsu_out_if.source out_if
);
  import tdcsu_pkg::*;

  localparam int unsigned IDX_W = (EPOCH_ENTRIES > 1) ? $clog2(EPOCH_ENTRIES) : 1;

  // parser state
  mode_t       mode_r, mode_nxt;
  logic [15:0] words_left_r, words_left_nxt;
  logic [15:0] cur_tdc_r, cur_tdc_nxt;
  logic        overflow_r, overflow_nxt;

  // epoch table: tags and valid bits in flops for the parallel compare,
  // epoch values in a synchronous memory
  logic [15:0]        tag_r   [EPOCH_ENTRIES];
  logic [EPOCH_ENTRIES-1:0] valid_r;
  logic [EPOCH_W-1:0] epoch_mem [EPOCH_ENTRIES];

  // output side
  logic               out_valid_r;
  logic [EPOCH_W-1:0] epoch_q_r;
  logic               epoch_hit_r;
  logic [15:0]        link_r, tdc_r;
  logic [6:0]         chan_r;
  logic [9:0]         fine_r;
  logic               edge_r;
  logic [COARSE_W-1:0] coarse_r;
  logic               ovf_out_r;

  logic        accept;
  logic [31:0] w;
  logic [15:0] hdr_id, hdr_cnt;
  logic        hit_any, free_any;
  logic [IDX_W-1:0] hit_idx, free_idx;
  logic        data_en;       // word is a data word of a block that is decoded
  logic        emit_hit;      // time word: produce a result
  logic        store_epoch;   // epoch word: update the table
  logic        mem_we;
  logic [IDX_W-1:0] mem_wa;
  logic        tag_we;
  mode_t       mode_eff;

  // a waiting hit blocks new words until it is taken
  assign in_if.ready = !out_valid_r || out_if.ready;
  assign accept      = in_if.valid && in_if.ready;
  assign w           = in_if.data_word;
  assign hdr_id      = w[15:0];
  assign hdr_cnt     = w[31:16];

  // sub_start forces header position before the word is used
  assign mode_eff = in_if.sub_start ? MODE_HEADER : mode_r;

  // parallel tag compare for the current block's tdc
  always_comb begin
    hit_any = 1'b0;
    hit_idx = '0;
    for (int i = 0; i < EPOCH_ENTRIES; i++) begin
      if (valid_r[i] && (tag_r[i] == cur_tdc_r)) begin
        hit_any = 1'b1;
        hit_idx = hit_idx | IDX_W'(i);
      end
    end
  end

  // lowest free entry
  always_comb begin
    free_any = 1'b0;
    free_idx = '0;
    for (int i = EPOCH_ENTRIES - 1; i >= 0; i--) begin
      if (!valid_r[i]) begin
        free_any = 1'b1;
        free_idx = IDX_W'(i);
      end
    end
  end

  // parser next state
  always_comb begin
    mode_nxt       = mode_eff;
    words_left_nxt = in_if.sub_start ? 16'd0 : words_left_r;
    cur_tdc_nxt    = cur_tdc_r;
    data_en        = 1'b0;
    case (mode_eff)
      MODE_DONE: begin
        // ignore everything until the next subevent
      end
      MODE_BLOCK: begin
        words_left_nxt = words_left_r - 16'd1;
        if (words_left_nxt == 16'd0) begin
          mode_nxt = MODE_HEADER;
        end
        data_en = (cur_tdc_r != ID_IGNORE_A) && (cur_tdc_r != ID_IGNORE_B);
      end
      default: begin
        if (hdr_id == ID_END) begin
          mode_nxt = MODE_DONE;
        end else if ((hdr_id >= ID_SKIP_LO) && (hdr_id <= ID_SKIP_HI)) begin
          mode_nxt = MODE_HEADER;
        end else begin
          cur_tdc_nxt    = hdr_id;
          words_left_nxt = hdr_cnt;
          mode_nxt       = (hdr_cnt != 16'd0) ? MODE_BLOCK : MODE_HEADER;
        end
      end
    endcase
  end

  assign emit_hit    = accept && data_en && w[31];
  assign store_epoch = accept && data_en && (w[31:29] == KIND_EPOCH);

  // epoch store: update the matching entry, else allocate, else flag overflow
  always_comb begin
    mem_we       = 1'b0;
    mem_wa       = hit_idx;
    tag_we       = 1'b0;
    overflow_nxt = overflow_r;
    if (store_epoch) begin
      if (hit_any) begin
        mem_we = 1'b1;
      end else if (free_any) begin
        mem_we = 1'b1;
        mem_wa = free_idx;
        tag_we = 1'b1;
      end else begin
        overflow_nxt = 1'b1;
      end
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r       <= MODE_HEADER;
      words_left_r <= '0;
      cur_tdc_r    <= '0;
      overflow_r   <= 1'b0;
      valid_r      <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (accept) begin
        mode_r       <= mode_nxt;
        words_left_r <= words_left_nxt;
        cur_tdc_r    <= cur_tdc_nxt;
        overflow_r   <= overflow_nxt;
        if (tag_we) begin
          valid_r[mem_wa] <= 1'b1;
        end
      end
      if (accept) begin
        out_valid_r <= emit_hit;
      end else if (out_if.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // tag store
  always_ff @(posedge clk) begin
    if (tag_we) begin
      tag_r[mem_wa] <= cur_tdc_r;
    end
  end

  // epoch value memory: one write port, one registered read port
  // a write and a read never share an edge, since each word is one or the other
  always_ff @(posedge clk) begin
    if (mem_we) begin
      epoch_mem[mem_wa] <= w[EPOCH_W-1:0];
    end
    if (emit_hit) begin
      epoch_q_r <= epoch_mem[hit_idx];
    end
  end

  // hit payload, held while the output is stalled
  always_ff @(posedge clk) begin
    if (emit_hit) begin
      epoch_hit_r <= hit_any;
      link_r      <= in_if.link_id;
      tdc_r       <= cur_tdc_r;
      chan_r      <= w[28:22];
      fine_r      <= w[21:12];
      edge_r      <= w[11];
      coarse_r    <= w[10:0];
      ovf_out_r   <= overflow_r;
    end
  end

  assign out_if.valid          = out_valid_r;
  assign out_if.link_number    = link_r;
  assign out_if.tdc_number     = tdc_r;
  assign out_if.channel        = chan_r;
  assign out_if.epoch_value    = epoch_hit_r ? epoch_q_r : '0;
  assign out_if.coarse_time    = coarse_r;
  assign out_if.fine_time      = fine_r;
  assign out_if.edge_bit       = edge_r;
  // epoch * 2048 + coarse is a plain concatenation
  assign out_if.full_coarse    = {out_if.epoch_value, coarse_r};
  assign out_if.table_overflow = ovf_out_r;

endmodule

### test/tdcsu_tb_pkg.sv
// hit prediction and scoreboard for the tdc subevent unpacker testbench
package tdcsu_tb_pkg;
  import tdcsu_pkg::*;

  typedef struct packed {
    logic [15:0] link_number;
    logic [15:0] tdc_number;
    logic [6:0]  channel;
    logic [27:0] epoch_value;
    logic [10:0] coarse_time;
    logic [9:0]  fine_time;
    logic        edge_bit;
    logic [38:0] full_coarse;
    logic        table_overflow;
  } hit_t;

  class hit_scoreboard;
    // parser and epoch table as the block should hold them
    mode_t       mode;
    logic [15:0] words_owed;
    logic [15:0] block_tdc;
    logic [15:0] slot_tag[EPOCH_ENTRIES_DEF];
    logic [27:0] slot_epoch[EPOCH_ENTRIES_DEF];
    bit          slot_used[EPOCH_ENTRIES_DEF];
    bit          table_full_seen;
    hit_t        pending_hits[$];
    int          errors;

    function new();
      mode = MODE_HEADER;
      words_owed = '0;
      block_tdc = '0;
      table_full_seen = 0;
      errors = 0;
      foreach (slot_used[i]) slot_used[i] = 0;
    endfunction

    // update the parser for one accepted request, queue the hit it yields
    function void note_word(logic [31:0] w, bit start, logic [15:0] link);
      hit_t h;
      int   slot;
      int   free_slot;
      if (start) begin
        mode = MODE_HEADER;
        words_owed = '0;
      end
      if (mode == MODE_DONE) return;
      if (mode != MODE_BLOCK) begin
        if (w[15:0] == ID_END) begin
          mode = MODE_DONE;
        end else if (w[15:0] >= ID_SKIP_LO && w[15:0] <= ID_SKIP_HI) begin
          mode = MODE_HEADER;
        end else begin
          block_tdc = w[15:0];
          words_owed = w[31:16];
          mode = (w[31:16] != 16'd0) ? MODE_BLOCK : MODE_HEADER;
        end
        return;
      end
      words_owed = words_owed - 16'd1;
      if (words_owed == 16'd0) mode = MODE_HEADER;
      if (block_tdc == ID_IGNORE_A || block_tdc == ID_IGNORE_B) return;
      slot = -1;
      free_slot = -1;
      foreach (slot_used[i]) begin
        if (slot_used[i] && slot_tag[i] == block_tdc && slot < 0) slot = i;
        if (!slot_used[i] && free_slot < 0) free_slot = i;
      end
      if (w[31]) begin
        h.link_number    = link;
        h.tdc_number     = block_tdc;
        h.channel        = w[28:22];
        h.epoch_value    = (slot >= 0) ? slot_epoch[slot] : 28'd0;
        h.coarse_time    = w[10:0];
        h.fine_time      = w[21:12];
        h.edge_bit       = w[11];
        h.full_coarse    = FULL_W'(h.epoch_value) * 39'd2048 + FULL_W'(h.coarse_time);
        h.table_overflow = table_full_seen;
        pending_hits = {pending_hits, h};
      end else if (w[31:29] == KIND_EPOCH) begin
        if (slot >= 0) begin
          slot_epoch[slot] = w[27:0];
        end else if (free_slot >= 0) begin
          slot_used[free_slot]  = 1;
          slot_tag[free_slot]   = block_tdc;
          slot_epoch[free_slot] = w[27:0];
        end else begin
          table_full_seen = 1;
        end
      end
    endfunction

    function void cmp_field(string name, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
        $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
        errors++;
      end
    endfunction

    // compare one accepted hit with the oldest predicted one
    function void check_hit(hit_t got);
      hit_t want;
      if (pending_hits.size() == 0) begin
        $error("unexpected hit: tdc 0x%0h channel %0d", got.tdc_number, got.channel);
        errors++;
        return;
      end
      want = pending_hits[0];
      pending_hits.delete(0);
      cmp_field("link_number", want.link_number, got.link_number);
      cmp_field("tdc_number", want.tdc_number, got.tdc_number);
      cmp_field("channel", want.channel, got.channel);
      cmp_field("epoch_value", want.epoch_value, got.epoch_value);
      cmp_field("coarse_time", want.coarse_time, got.coarse_time);
      cmp_field("fine_time", want.fine_time, got.fine_time);
      cmp_field("edge_bit", want.edge_bit, got.edge_bit);
      cmp_field("full_coarse", want.full_coarse, got.full_coarse);
      cmp_field("table_overflow", want.table_overflow, got.table_overflow);
    endfunction

    function int pending_count();
      return pending_hits.size();
    endfunction
  endclass

endpackage

### test/tb_tdc_subevent_unpacker.sv
// top level testbench of the tdc subevent unpacker: directed and random subevents
module tb_tdc_subevent_unpacker;
  timeunit 1ns;
  timeprecision 1ps;

  import tdcsu_pkg::*;
  import tdcsu_tb_pkg::*;

  // cycles without any accepted request before the run is declared hung
  localparam int QUIET_LIMIT   = 3000;
  // word requests per random phase, four phases
  localparam int PHASE_WORDS   = 325;
  // cycles to let the output register drain at the end
  localparam int DRAIN_CYCLES  = 10;

  logic clk = 1'b0;
  logic rst_n;

  tdcsu_in_if  in_ch();
  tdcsu_out_if out_ch();

  tdc_subevent_unpacker dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_ch),
    .out_if (out_ch)
  );

  hit_scoreboard hits;
  int idle_pct = 0;       // chance in percent that the sender idles a cycle
  int stall_pct = 0;      // chance in percent that the receiver stalls a cycle
  int words_sent = 0;     // counts accepted requests, less the noise words after an end marker
  int quiet_cycles = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // receiver: ready changes only at the falling edge
  always @(negedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= stall_pct);
  end

  // every accepted hit goes straight to the scoreboard
  always @(posedge clk) begin : watch_hits
    hit_t got;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got.link_number    = out_ch.link_number;
      got.tdc_number     = out_ch.tdc_number;
      got.channel        = out_ch.channel;
      got.epoch_value    = out_ch.epoch_value;
      got.coarse_time    = out_ch.coarse_time;
      got.fine_time      = out_ch.fine_time;
      got.edge_bit       = out_ch.edge_bit;
      got.full_coarse    = out_ch.full_coarse;
      got.table_overflow = out_ch.table_overflow;
      hits.check_hit(got);
    end
  end

  // watchdog: a run that stops moving on both channels is a failure
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= QUIET_LIMIT) begin
        $display("tb_tdc_subevent_unpacker: FAIL");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // one word request; random idle cycles ahead of it, held until accepted
  task automatic send_word(input logic [31:0] w, input bit start, input logic [15:0] link);
    bit accepted;
    accepted = 0;
    @(negedge clk);
    while ($urandom_range(99) < idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.data_word <= w;
    in_ch.sub_start <= start;
    in_ch.link_id   <= link;
    while (!accepted) begin
      @(posedge clk);
      if (in_ch.ready) accepted = 1;
      else @(negedge clk);
    end
    hits.note_word(w, start, link);
    words_sent++;
  endtask

  // mostly a small pool of tdc ids, more of them than the epoch table holds,
  // so the table fills up and overflows during the random part
  function automatic logic [15:0] pick_tdc();
    int r;
    r = $urandom_range(99);
    if (r < 85) return 16'h0100 + 16'($urandom_range(19));
    if (r < 92) return ID_IGNORE_A;
    return 16'($urandom());
  endfunction

  // block data: time words, epoch words with some extreme values, other kinds
  function automatic logic [31:0] pick_data();
    int r;
    logic [27:0] epoch;
    r = $urandom_range(99);
    if (r < 55) return {1'b1, 31'($urandom())};
    if (r < 80) begin
      epoch = 28'($urandom());
      if ($urandom_range(9) == 0) epoch = '0;
      if ($urandom_range(9) == 0) epoch = '1;
      return {KIND_EPOCH, 1'b0, epoch};
    end
    return {3'($urandom_range(2)), 29'($urandom())};
  endfunction

  // a well-formed subevent with random content; some blocks are cut short
  // by the next subevent start, some subevents miss their end marker
  task automatic send_subevent();
    int  nblocks;
    int  count;
    int  nsend;
    int  r;
    int  noise;
    bit  first;
    logic [15:0] id;
    first = 1;
    nblocks = $urandom_range(1, 6);
    for (int b = 0; b < nblocks; b++) begin
      r = $urandom_range(99);
      if (r < 8) begin
        // single-word skip header
        send_word({16'($urandom()), ID_SKIP_LO + 16'($urandom_range(3))}, first,
                  16'($urandom()));
        first = 0;
      end else begin
        id = pick_tdc();
        r = $urandom_range(99);
        if (r < 5) begin
          count = 0;
          nsend = 0;
        end else if (r < 8) begin
          count = $urandom_range(16, 65535);
          nsend = $urandom_range(1, 6);
        end else begin
          count = $urandom_range(1, 8);
          nsend = count;
        end
        send_word({16'(count), id}, first, 16'($urandom()));
        first = 0;
        for (int i = 0; i < nsend; i++) send_word(pick_data(), 1'b0, 16'($urandom()));
        if (nsend < count) return;
      end
    end
    if ($urandom_range(99) < 70) begin
      send_word({16'($urandom()), ID_END}, 1'b0, 16'($urandom()));
      // words after the end marker are dropped by the parser
      noise = $urandom_range(3);
      for (int i = 0; i < noise; i++) send_word($urandom(), 1'b0, 16'($urandom()));
      words_sent -= noise;
    end
  endtask

  // directed part: field extremes, every header kind and the special cases
  task automatic run_directed();
    // time word before any epoch is stored, all fields at their maximum
    send_word({16'd3, 16'h0001}, 1'b1, 16'hffff);
    send_word(32'hffff_ffff, 1'b0, 16'hffff);
    // largest epoch, then a time word with all fields zero
    send_word({KIND_EPOCH, 1'b0, 28'hfff_ffff}, 1'b0, 16'h0000);
    send_word(32'h8000_0000, 1'b0, 16'h0000);
    // both ends of the skip id range in header position
    send_word({16'hffff, ID_SKIP_LO}, 1'b0, 16'h1234);
    send_word({16'h0000, ID_SKIP_HI}, 1'b0, 16'h1234);
    // zero-length block only changes the current tdc
    send_word({16'd0, 16'h0002}, 1'b0, 16'h0001);
    // ignored tdc: time, epoch and a skip-looking word are all dropped
    send_word({16'd4, ID_IGNORE_A}, 1'b0, 16'h0002);
    send_word(32'hffff_ffff, 1'b0, 16'h0002);
    send_word({KIND_EPOCH, 1'b0, 28'h123_4567}, 1'b0, 16'h0002);
    send_word(32'h8000_0400, 1'b0, 16'h0002);
    send_word({16'h0000, ID_SKIP_LO + 16'd1}, 1'b0, 16'h0002);
    send_word({16'd2, ID_IGNORE_B}, 1'b0, 16'h0003);
    send_word(32'hc00f_f7ff, 1'b0, 16'h0003);
    send_word(32'h8000_0001, 1'b0, 16'h0003);
    // largest tdc id, zero epoch, then an end marker inside the block as data
    send_word({16'd3, 16'hffff}, 1'b0, 16'h8000);
    send_word({KIND_EPOCH, 1'b0, 28'h0}, 1'b0, 16'h8000);
    send_word(32'h8020_07ff, 1'b0, 16'h8000);
    send_word({16'h0000, ID_END}, 1'b0, 16'h8000);
    // end marker, then a word that must be ignored
    send_word({16'h1234, ID_END}, 1'b0, 16'h0004);
    send_word(32'hffff_ffff, 1'b0, 16'h0004);
    // epoch kept over a new subevent; full coarse at its maximum
    send_word({16'd1, 16'h0001}, 1'b1, 16'h7fff);
    send_word(32'h8000_07ff, 1'b0, 16'h7fff);
    // subevent start in the middle of a block restarts the parser
    send_word({16'd5, 16'h0003}, 1'b0, 16'h0005);
    send_word({16'd1, 16'h0001}, 1'b1, 16'h0006);
  endtask

  initial begin
    int target;
    int pct[4][2];
    pct = '{'{0, 0}, '{87, 0}, '{0, 87}, '{30, 30}};
    hits = new();
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.data_word = '0;
    in_ch.sub_start = 1'b0;
    in_ch.link_id = '0;
    out_ch.ready = 1'b0;
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;

    run_directed();

    // random part in four idling phases
    for (int phase = 0; phase < 4; phase++) begin
      idle_pct = pct[phase][0];
      stall_pct = pct[phase][1];
      target = words_sent + PHASE_WORDS;
      while (words_sent < target) begin
        if ($urandom_range(99) < 10) begin
          // broken stream: a raw word, sometimes flagged as a subevent start
          send_word($urandom(), ($urandom_range(9) == 0), 16'($urandom()));
        end else begin
          send_subevent();
        end
      end
    end

    @(negedge clk);
    in_ch.valid <= 1'b0;
    // wait for the outstanding hits; the watchdog bounds this wait
    while (hits.pending_count() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (hits.errors == 0) begin
      $display("tb_tdc_subevent_unpacker: PASS");
    end else begin
      $display("tb_tdc_subevent_unpacker: FAIL");
    end
    $finish;
  end

endmodule
